>>> rtl/tlg_pkg.sv
`timescale 1ns / 1ps

package tlg_pkg;

    // Default build values
    localparam int SINE_TABLE_BITS_DEF = 8;
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int CHANNELS_DEF        = 2;

    // Channel select field is sized for the largest channel count (8)
    localparam int CHAN_SEL_W = 3;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEPTH      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WAVEFORM   = 2'd2;

    localparam logic [30:0] PHASE_STEP_RST = 31'd447392;
    localparam logic [15:0] DEPTH_RST      = 16'd22938;
    localparam logic [1:0]  WAVEFORM_RST   = 2'd0;

    // Waveform codes; anything else runs the sine
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SQUARE   = 2'd2;

    localparam logic [16:0] DEPTH_FULL = 17'd32768;

    // Odd Taylor polynomial of sin(pi/2*x) in Q30
    localparam logic signed [31:0] SIN_C9 = 32'sd172273;

    function automatic logic signed [31:0] sin_coef(input logic [1:0] k);
        logic signed [31:0] c;
        unique case (k)
            2'd0:    c = -32'sd5026994;
            2'd1:    c = 32'sd85569302;
            2'd2:    c = -32'sd693598668;
            2'd3:    c = 32'sd1686629713;
            default: c = 32'sd0;
        endcase
        return c;
    endfunction

    // Datapath commands
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_XX,
        OP_X2,
        OP_HMUL,
        OP_HADD,
        OP_MUL_PX,
        OP_LFO,
        OP_MUL_D,
        OP_GAIN,
        OP_MUL_S,
        OP_STORE,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [1:0]            coef_sel;
        logic [CHAN_SEL_W-1:0] chan;
    } cmd_t;

endpackage

>>> rtl/tlg_ctrl.sv
`timescale 1ns / 1ps

module tlg_ctrl #(
    parameter int CHANNELS = tlg_pkg::CHANNELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output tlg_pkg::cmd_t cmd
);
    import tlg_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL_XX = 4'd1;
    localparam logic [3:0] ST_X2     = 4'd2;
    localparam logic [3:0] ST_HMUL   = 4'd3;
    localparam logic [3:0] ST_HADD   = 4'd4;
    localparam logic [3:0] ST_MUL_PX = 4'd5;
    localparam logic [3:0] ST_LFO    = 4'd6;
    localparam logic [3:0] ST_MUL_D  = 4'd7;
    localparam logic [3:0] ST_GAIN   = 4'd8;
    localparam logic [3:0] ST_MUL_S  = 4'd9;
    localparam logic [3:0] ST_STORE  = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    logic [3:0]      state_reg, state_next;
    logic [1:0]      k_reg, k_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic            m_tvalid_reg, m_tvalid_next;
    op_t             op;
    logic            out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        ch_next    = ch_reg;
        op         = OP_NOP;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op         = OP_LOAD;
                    state_next = ST_MUL_XX;
                end
            end
            ST_MUL_XX:
            begin
                op         = OP_MUL_XX;
                state_next = ST_X2;
            end
            ST_X2:
            begin
                op         = OP_X2;
                k_next     = 2'd0;
                state_next = ST_HMUL;
            end
            ST_HMUL:
            begin
                op         = OP_HMUL;
                state_next = ST_HADD;
            end
            ST_HADD:
            begin
                op = OP_HADD;
                if (k_reg == 2'd3)
                begin
                    state_next = ST_MUL_PX;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_HMUL;
                end
            end
            ST_MUL_PX:
            begin
                op         = OP_MUL_PX;
                state_next = ST_LFO;
            end
            ST_LFO:
            begin
                op         = OP_LFO;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                op         = OP_MUL_D;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                op         = OP_GAIN;
                ch_next    = '0;
                state_next = ST_MUL_S;
            end
            ST_MUL_S:
            begin
                op         = OP_MUL_S;
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                op = OP_STORE;
                if (ch_reg == LAST_CH)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_MUL_S;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    op         = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (op == OP_OUT)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign cmd.op       = op;
    assign cmd.coef_sel = k_reg;
    assign cmd.chan     = CHAN_SEL_W'(ch_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            ch_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            ch_reg       <= ch_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A pending result is never overwritten
    a_out_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_OUT) |-> (!m_tvalid_reg || m_tready))
        else $error("result register loaded while previous item still pending");

    // An accepted item starts the multiply sequence
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL_XX))
        else $error("accepted item did not start the sequence");

    // The sine product only follows the last Horner step
    a_horner_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_PX) |-> ($past(state_reg) == ST_HADD && $past(k_reg) == 2'd3))
        else $error("polynomial evaluation cut short");

    // Stalled output keeps the sequencer parked
    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_free) |=> (state_reg == ST_OUT))
        else $error("sequencer left output wait while result pending");
`endif

endmodule

>>> rtl/tlg_datapath.sv
`timescale 1ns / 1ps

module tlg_datapath #(
    parameter int SINE_TABLE_BITS = tlg_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = tlg_pkg::SAMPLE_BITS_DEF,
    parameter int CHANNELS        = tlg_pkg::CHANNELS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  tlg_pkg::cmd_t                                cmd,
    input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    input  logic                                         s_tlast,
    output logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
    output logic                                         m_tlast,
    input  logic                                         cfg_we,
    input  logic [tlg_pkg::CFG_ADDR_W-1:0]               cfg_addr,
    input  logic [tlg_pkg::CFG_DATA_W-1:0]               cfg_wdata
);
    import tlg_pkg::*;

    localparam int B    = SINE_TABLE_BITS;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration
    logic [30:0] phase_step_reg;
    logic [15:0] depth_reg;
    logic [1:0]  waveform_reg;

    // Working registers
    logic [31:0]              phase_acc_reg;
    logic [31:0]              ph_reg;
    logic signed [31:0]       x_reg;
    logic signed [31:0]       x2_reg;
    logic signed [31:0]       p_reg;
    logic signed [63:0]       prod_reg;
    logic signed [15:0]       lfo_reg;
    logic [16:0]              gain_reg;
    logic signed [SAMPLE_BITS-1:0] samp_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] y_reg    [CHANNELS];
    logic [SAMPLE_BITS-1:0]   out_reg  [CHANNELS];
    logic                     last_reg;
    logic                     out_last_reg;

    logic [CH_W-1:0]    ch;
    logic [B-1:0]       idx;
    logic [B:0]         mag_idx;
    logic signed [31:0] x_new;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_adj;
    logic signed [63:0] prod_q30;
    logic signed [63:0] prod_y;
    logic signed [32:0] r_round;
    logic signed [32:0] r_shift;
    logic [14:0]        sin_mag;
    logic signed [15:0] sin_val;
    logic [16:0]        tri_t;
    logic signed [17:0] tri_v;
    logic signed [15:0] tri_val;
    logic signed [15:0] sq_val;
    logic [16:0]        depth_sat;

    assign ch = cmd.chan[CH_W-1:0];

    // Quarter-wave index mirrored on odd quadrants, then scaled to Q30
    assign idx     = phase_acc_reg[29 -: B];
    assign mag_idx = phase_acc_reg[30] ? ((B+1)'(1) << B) - {1'b0, idx} : {1'b0, idx};
    assign x_new   = $signed({1'b0, mag_idx, {(30-B){1'b0}}});

    // Q30 product, truncated toward zero
    assign prod_adj = prod_reg + (prod_reg[63] ? 64'sd1073741823 : 64'sd0);
    assign prod_q30 = prod_adj >>> 30;

    // Sine magnitude: round to Q15 and clamp
    assign r_round = 33'(prod_q30[31:0]) + 33'sd16384;
    assign r_shift = r_round >>> 15;
    always_comb
    begin
        if (r_shift < 0)
        begin
            sin_mag = '0;
        end
        else if (r_shift > 33'sd32767)
        begin
            sin_mag = 15'h7fff;
        end
        else
        begin
            sin_mag = r_shift[14:0];
        end
    end
    assign sin_val = ph_reg[31] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});

    // Triangle from the top phase bits, peak clamped
    assign tri_t = ph_reg[31:15];
    assign tri_v = ph_reg[31] ? (18'sd98304 - $signed({1'b0, tri_t}))
                              : ($signed({1'b0, tri_t}) - 18'sd32768);
    assign tri_val = (tri_v > 18'sd32767) ? 16'sd32767 : tri_v[15:0];

    assign sq_val = ph_reg[31] ? -16'sd32768 : 16'sd32767;

    assign depth_sat = ({1'b0, depth_reg} > DEPTH_FULL) ? DEPTH_FULL : {1'b0, depth_reg};

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_XX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            OP_HMUL:
            begin
                mul_a = p_reg;
                mul_b = x2_reg;
            end
            OP_MUL_PX:
            begin
                mul_a = p_reg;
                mul_b = x_reg;
            end
            OP_MUL_D:
            begin
                mul_a = $signed({15'b0, depth_sat});
                mul_b = 32'sd32768 - 32'(lfo_reg);
            end
            OP_MUL_S:
            begin
                mul_a = 32'(samp_reg[ch]);
                mul_b = $signed({15'b0, gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_y = prod_reg >>> 15;

    // Configuration and phase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RST;
            depth_reg      <= DEPTH_RST;
            waveform_reg   <= WAVEFORM_RST;
            phase_acc_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_PHASE_STEP: phase_step_reg <= cfg_wdata;
                    REG_DEPTH:      depth_reg      <= cfg_wdata[15:0];
                    REG_WAVEFORM:   waveform_reg   <= cfg_wdata[1:0];
                    default:        ;
                endcase
            end
            if (cmd.op == OP_LOAD)
            begin
                phase_acc_reg <= phase_acc_reg + {1'b0, phase_step_reg};
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                ph_reg   <= phase_acc_reg;
                x_reg    <= x_new;
                last_reg <= s_tlast;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    samp_reg[c] <= s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
                end
            end
            OP_MUL_XX, OP_HMUL, OP_MUL_PX, OP_MUL_D, OP_MUL_S:
            begin
                prod_reg <= mul_a * mul_b;
            end
            OP_X2:
            begin
                x2_reg <= prod_q30[31:0];
                p_reg  <= SIN_C9;
            end
            OP_HADD:
            begin
                p_reg <= sin_coef(cmd.coef_sel) + prod_q30[31:0];
            end
            OP_LFO:
            begin
                if (waveform_reg == WAVE_TRIANGLE)
                begin
                    lfo_reg <= tri_val;
                end
                else if (waveform_reg == WAVE_SQUARE)
                begin
                    lfo_reg <= sq_val;
                end
                else
                begin
                    lfo_reg <= sin_val;
                end
            end
            OP_GAIN:
            begin
                gain_reg <= 17'd32768 - prod_reg[32:16];
            end
            OP_STORE:
            begin
                y_reg[ch] <= prod_y[SAMPLE_BITS-1:0];
            end
            OP_OUT:
            begin
                out_last_reg <= last_reg;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    out_reg[c] <= y_reg[c];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        m_tdata = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] = out_reg[c];
        end
    end

    assign m_tlast = out_last_reg;

endmodule

>>> rtl/tremolo_lfo_gain_unit.sv
`timescale 1ns / 1ps

// Channel   | Signals                                | Carries
// ----------+----------------------------------------+------------------------------------
// s (in)    | s_tvalid s_tready s_tdata s_tlast      | one frame: samples, block-end mark
// m (out)   | m_tvalid m_tready m_tdata m_tlast      | one modulated frame, mark copied
// cfg       | cfg_we cfg_addr cfg_wdata              | 0 phase_step, 1 depth, 2 waveform
//
// One item at a time; each goes through the single shared 32x32 multiplier in turn:
// LFO polynomial (6 products), gain (1), then one product per channel.
// The LFO uses the phase before the item; the phase advances when the item is taken.
// Reset (rst_n low, async) clears the phase and loads the register defaults.
// A finished item waits in the output register; the next item is taken meanwhile and
// the sequencer only parks if that item finishes while the previous one is still held.

module tremolo_lfo_gain_unit #(
    parameter int SINE_TABLE_BITS = tlg_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = tlg_pkg::SAMPLE_BITS_DEF,
    parameter int CHANNELS        = tlg_pkg::CHANNELS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // s_tdata: left_in, right_in (one SAMPLE_BITS lane per channel), zero pad
    input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                      s_tlast,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // m_tdata: left_out, right_out (one SAMPLE_BITS lane per channel), zero pad
    output logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                      m_tlast,
    input  logic                                      cfg_we,
    input  logic [tlg_pkg::CFG_ADDR_W-1:0]            cfg_addr,
    input  logic [tlg_pkg::CFG_DATA_W-1:0]            cfg_wdata
);
    import tlg_pkg::*;

    cmd_t cmd;

    // Sequencer: steps the shared multiplier through the per-item schedule
    tlg_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Phase accumulator, LFO, gain and per-channel scaling
    tlg_datapath #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .CHANNELS        (CHANNELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

>>> tb/sv/tb_tremolo_lfo_gain_unit.sv
`timescale 1ns / 1ps

// Tremolo block bench: stereo frames go in on the s side, modulated frames come
// back on the m side. The bench keeps its own copy of the LFO phase and of the three
// registers, computes each expected frame (or takes a hand-typed one) when the input
// item is taken, and checks each output item against the oldest pending frame.

module tb_tremolo_lfo_gain_unit;
    import tlg_pkg::*;

    localparam int SAMPLE_W   = 24;
    localparam int DATA_W     = 48;
    localparam int TABLE_BITS = 8;

    // Register index the block has no register behind
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    // Sine codes: zero, and three which the block treats the same way
    localparam logic [1:0] WAVE_SINE       = 2'd0;
    localparam logic [1:0] WAVE_SINE_ALIAS = 2'd3;

    // Taylor coefficients of sin(pi/2*x), Q30
    localparam longint Q30_ONE = 1073741824;
    localparam longint SIN_K1  = 1686629713;
    localparam longint SIN_K3  = -693598668;
    localparam longint SIN_K5  = 85569302;
    localparam longint SIN_K7  = -5026994;
    localparam longint SIN_K9  = 172273;

    localparam logic [SAMPLE_W-1:0] S_MAX  = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] S_MIN  = 24'h800000;
    localparam logic [SAMPLE_W-1:0] S_NEG1 = 24'hFFFFFF;

    localparam int RANDOM_ITEMS  = 1900;
    localparam int SETTLE_CYCLES = 24;   // one frame plus margin
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 2000; // cycles with no item moving on either side

    typedef struct packed {
        logic                       last;
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } frame_t;

    typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
        frame_t                stim;
        bit                    known;   // want holds a hand-typed result
        frame_t                want;
    } stim_row_t;

    typedef enum logic [1:0] {READY_ON, READY_COIN, READY_STALL, READY_TOGGLE} ready_mode_t;

    // DUT ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;   // left_in [23:0], right_in [47:24]
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;          // left_out [23:0], right_out [47:24]
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Bench copy of the block state
    logic [31:0] lfo_phase = '0;
    logic [30:0] step_cfg  = PHASE_STEP_RST;
    logic [15:0] depth_cfg = DEPTH_RST;
    logic [1:0]  wave_cfg  = WAVE_SINE;

    frame_t      expected_frames[$];
    stim_row_t   dir_rows[$];
    int          errors      = 0;
    int          idle_cycles = 0;

    // Sender burst shaping
    int          burst_left = 0;
    int          gap_max    = 6;

    // Receiver stall pattern
    ready_mode_t ready_mode = READY_ON;
    int          ready_run  = 0;

    always #5 clk = ~clk;

    tremolo_lfo_gain_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t ns  mismatch: %s", $time, what);
    endtask

    // Quarter-wave table entry: Horner in Q30, each product truncated toward zero,
    // then rounded half-up to Q15 and clipped to [0, 32767].
    function automatic longint quarter_sine(input int unsigned i);
        longint x, x2, p, r;
        x  = longint'(i) << (30 - TABLE_BITS);
        x2 = (x * x) / Q30_ONE;
        p  = SIN_K7 + (SIN_K9 * x2) / Q30_ONE;
        p  = SIN_K5 + (p * x2) / Q30_ONE;
        p  = SIN_K3 + (p * x2) / Q30_ONE;
        p  = SIN_K1 + (p * x2) / Q30_ONE;
        r  = (p * x) / Q30_ONE;
        r  = (r + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < 0)
            r = 0;
        return r;
    endfunction

    // LFO level in Q1.15 for a given phase under the current waveform code
    function automatic longint lfo_level(input logic [31:0] ph);
        longint                t, v, mag;
        logic [TABLE_BITS-1:0] idx;
        case (wave_cfg)
            WAVE_TRIANGLE:
            begin
                t = longint'(ph >> 15);
                v = ph[31] ? 98304 - t : t - 32768;
                if (v > 32767)
                    v = 32767;
            end
            WAVE_SQUARE:
            begin
                v = ph[31] ? -32768 : 32767;
            end
            default:
            begin
                // quadrant in the top two bits; odd quadrants read the table backwards
                idx = ph[29 -: TABLE_BITS];
                mag = ph[30] ? quarter_sine((1 << TABLE_BITS) - idx) : quarter_sine(idx);
                v   = ph[31] ? -mag : mag;
            end
        endcase
        return v;
    endfunction

    // Expected output frame for one input frame; advances the phase afterwards
    function automatic frame_t modulate_frame(input frame_t f);
        frame_t y;
        longint lfo, d, gain, prod;
        lfo  = lfo_level(lfo_phase);
        d    = (depth_cfg > DEPTH_FULL) ? longint'(DEPTH_FULL) : longint'(depth_cfg);
        gain = 32768 - ((d * (32768 - lfo)) >>> 16);
        prod = (longint'(f.left) * gain) >>> 15;
        y.left = prod[SAMPLE_W-1:0];
        prod = (longint'(f.right) * gain) >>> 15;
        y.right = prod[SAMPLE_W-1:0];
        y.last = f.last;
        lfo_phase = lfo_phase + {1'b0, step_cfg};
        return y;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 7))
            0:       s = S_MAX;
            1:       s = S_MIN;
            2:       s = '0;
            3:       s = S_NEG1;
            4:       s = SAMPLE_W'($urandom_range(0, 255));
            default: s = SAMPLE_W'($urandom);
        endcase
        return s;
    endfunction

    function automatic stim_row_t write_row(input logic [CFG_ADDR_W-1:0] a,
                                            input logic [CFG_DATA_W-1:0] d);
        stim_row_t r;
        r.kind  = ROW_WRITE;
        r.addr  = a;
        r.data  = d;
        r.stim  = '0;
        r.known = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic stim_row_t frame_row(input logic [SAMPLE_W-1:0] l,
                                            input logic [SAMPLE_W-1:0] rr,
                                            input logic last);
        stim_row_t r;
        r.kind  = ROW_FRAME;
        r.addr  = '0;
        r.data  = '0;
        r.stim  = {last, rr, l};
        r.known = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic stim_row_t known_row(input logic [SAMPLE_W-1:0] l,
                                            input logic [SAMPLE_W-1:0] rr,
                                            input logic last,
                                            input logic [SAMPLE_W-1:0] wl,
                                            input logic [SAMPLE_W-1:0] wr);
        stim_row_t r;
        r = frame_row(l, rr, last);
        r.known = 1'b1;
        r.want  = {last, wr, wl};
        return r;
    endfunction

    // Offer one frame; idle gaps fall between bursts. valid is only lowered when a
    // real gap follows, so it never drops and rises within one step.
    task automatic send_frame(input frame_t f, input bit known, input frame_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tdata  <= {f.right, f.left};
        s_tlast  <= f.last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        if (known)
        begin
            void'(modulate_frame(f));   // phase still moves on
            expected_frames.push_back(want);
        end
        else
        begin
            expected_frames.push_back(modulate_frame(f));
        end
    endtask

    // Stop offering and let everything in flight come out
    task automatic quiesce();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (addr)
            REG_PHASE_STEP: step_cfg  = data;
            REG_DEPTH:      depth_cfg = data[15:0];
            REG_WAVEFORM:   wave_cfg  = data[1:0];
            default:        ;   // no register there
        endcase
    endtask

    // Output side: check on each accepted item, then pick the next ready level
    always @(posedge clk)
    begin : result_side
        frame_t got;
        frame_t want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tlast, m_tdata[2*SAMPLE_W-1:SAMPLE_W], m_tdata[SAMPLE_W-1:0]};
            if (expected_frames.size() == 0)
            begin
                report_mismatch("output item with no frame pending");
            end
            else
            begin
                want = expected_frames.pop_front();
                if (got.left !== want.left)
                    report_mismatch($sformatf("left %0d, want %0d", got.left, want.left));
                if (got.right !== want.right)
                    report_mismatch($sformatf("right %0d, want %0d", got.right, want.right));
                if (got.last !== want.last)
                    report_mismatch($sformatf("tlast %b, want %b", got.last, want.last));
            end
        end
        if (ready_run == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_run  = (ready_mode == READY_STALL) ? $urandom_range(1, 30)
                                                     : $urandom_range(4, 80);
        end
        ready_run--;
        case (ready_mode)
            READY_ON:    m_tready <= 1'b1;
            READY_COIN:  m_tready <= 1'($urandom_range(0, 1));
            READY_STALL: m_tready <= 1'b0;
            default:     m_tready <= ~m_tready;
        endcase
    end

    // Watchdog: too long with nothing moving means the block is stuck
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : main_flow
        stim_row_t           row;
        frame_t              f;
        logic [CFG_DATA_W-1:0] step_pick;
        logic [CFG_DATA_W-1:0] depth_pick;
        int                  n_random;
        int                  run_len;
        int                  last_odds;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // ---- directed table ----
        // Straight out of reset: phase zero, sine at zero, reset depth, so gain 21299
        dir_rows.push_back(known_row(S_MAX, S_MIN, 1'b0, 24'sd5452543, -24'sd5452544));
        dir_rows.push_back(frame_row(24'h000000, S_NEG1, 1'b1));
        // Steps of 0x2000_0000 walk the sine through its first three quadrants
        dir_rows.push_back(write_row(REG_PHASE_STEP, 31'h2000_0000));
        dir_rows.push_back(frame_row(S_MAX, S_MAX, 1'b0));
        dir_rows.push_back(frame_row(S_MIN, S_MIN, 1'b0));
        dir_rows.push_back(frame_row(24'h000001, S_NEG1, 1'b1));
        dir_rows.push_back(frame_row(24'h123456, 24'hEDCBA9, 1'b0));
        dir_rows.push_back(frame_row(S_MIN, S_MAX, 1'b0));
        dir_rows.push_back(frame_row(24'h5A5A5A, 24'hA5A5A5, 1'b1));
        // Triangle waveform
        dir_rows.push_back(write_row(REG_WAVEFORM, CFG_DATA_W'(WAVE_TRIANGLE)));
        dir_rows.push_back(frame_row(S_MAX, S_MIN, 1'b0));
        dir_rows.push_back(frame_row(S_MIN, S_MAX, 1'b0));
        dir_rows.push_back(frame_row(S_NEG1, 24'h000001, 1'b0));
        dir_rows.push_back(frame_row(S_MAX, S_MAX, 1'b1));
        // Square at full depth: unity gain in the first half cycle, silence in the second
        dir_rows.push_back(write_row(REG_WAVEFORM, CFG_DATA_W'(WAVE_SQUARE)));
        dir_rows.push_back(write_row(REG_DEPTH, CFG_DATA_W'(DEPTH_FULL)));
        dir_rows.push_back(frame_row(S_MAX, S_MIN, 1'b0));
        dir_rows.push_back(frame_row(S_MIN, S_MAX, 1'b0));
        dir_rows.push_back(frame_row(S_MAX, S_NEG1, 1'b0));
        dir_rows.push_back(frame_row(S_NEG1, S_MIN, 1'b1));
        // Code three falls back to the sine
        dir_rows.push_back(write_row(REG_WAVEFORM, CFG_DATA_W'(WAVE_SINE_ALIAS)));
        dir_rows.push_back(frame_row(S_MAX, S_MIN, 1'b0));
        dir_rows.push_back(frame_row(S_MIN, S_MAX, 1'b1));
        // Write to the empty index must leave every register alone
        dir_rows.push_back(write_row(REG_UNUSED, 31'h7FFF_FFFF));
        dir_rows.push_back(frame_row(S_MAX, S_MIN, 1'b0));
        // All data bits set: depth field reads 0xFFFF and clips to full depth
        dir_rows.push_back(write_row(REG_DEPTH, 31'h7FFF_FFFF));
        dir_rows.push_back(frame_row(S_MAX, S_MIN, 1'b0));
        dir_rows.push_back(frame_row(S_MIN, S_MAX, 1'b1));
        // Zero depth: gain is exactly one at any phase
        dir_rows.push_back(write_row(REG_DEPTH, 31'h0));
        dir_rows.push_back(known_row(S_MAX, S_MIN, 1'b0, S_MAX, S_MIN));
        dir_rows.push_back(known_row(S_NEG1, 24'h000001, 1'b1, S_NEG1, 24'h000001));
        // Largest step, back to defaults otherwise
        dir_rows.push_back(write_row(REG_PHASE_STEP, 31'h7FFF_FFFF));
        dir_rows.push_back(write_row(REG_DEPTH, CFG_DATA_W'(DEPTH_RST)));
        dir_rows.push_back(write_row(REG_WAVEFORM, CFG_DATA_W'(WAVE_SINE)));
        dir_rows.push_back(frame_row(S_MAX, S_MIN, 1'b0));
        dir_rows.push_back(frame_row(S_MIN, S_MAX, 1'b1));

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                quiesce();
                write_reg(row.addr, row.data);
            end
            else
            begin
                send_frame(row.stim, row.known, row.want);
            end
        end

        // ---- random phases: new settings, then a run of random frames ----
        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            quiesce();

            case ($urandom_range(0, 4))
                0:       step_pick = '0;
                1:       step_pick = 31'h7FFF_FFFF;
                2:       step_pick = CFG_DATA_W'($urandom_range(1, 1 << 22));
                3:       step_pick = CFG_DATA_W'($urandom);
                default: step_pick = CFG_DATA_W'(32'h4000_0000 ^ $urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 4))
                0:       depth_pick = '0;
                1:       depth_pick = CFG_DATA_W'(DEPTH_FULL);
                2:       depth_pick = CFG_DATA_W'($urandom_range(0, 32768));
                3:       depth_pick = CFG_DATA_W'($urandom_range(32769, 65535));
                default: depth_pick = CFG_DATA_W'($urandom);   // upper bits dropped by the block
            endcase
            write_reg(REG_PHASE_STEP, step_pick);
            write_reg(REG_DEPTH, depth_pick);
            write_reg(REG_WAVEFORM, CFG_DATA_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

            case ($urandom_range(0, 2))
                0:       gap_max = 0;    // back-to-back
                1:       gap_max = 4;
                default: gap_max = 40;
            endcase
            last_odds = $urandom_range(1, 8);
            run_len   = $urandom_range(40, 220);

            repeat (run_len)
            begin
                f.left  = pick_sample();
                f.right = pick_sample();
                f.last  = ($urandom_range(0, last_odds - 1) == 0);
                send_frame(f, 1'b0, f);
            end
            n_random += run_len;
        end

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_frames.size() != 0)
            report_mismatch($sformatf("%0d frames never came out", expected_frames.size()));

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
